>>> hw/rtl/wuf_pkg.sv
// Shared types and fixed widths for the weighted union-find block.
// No dependencies; imported by every module of the block but wuf_fifo.
package wuf_pkg;

  localparam int SITE_W = 10;  // width of a site index on the ports
  localparam int CNT_W  = 11;  // width of counts, tree sizes and sites_in_use

  // Classified item, front to back
  typedef struct packed {
    logic [SITE_W-1:0] first_site;
    logic [SITE_W-1:0] second_site;
    logic              index_error;
  } wuf_cmd_t;

  // Result item, back to result queue
  typedef struct packed {
    logic             already_joined;
    logic             index_error;
    logic [CNT_W-1:0] components;
  } wuf_res_t;

  // Control from front to back
  typedef struct packed {
    logic             restart;  // configuration write: reinitialise the forest
    logic [CNT_W-1:0] sites;    // current sites_in_use
  } wuf_ctl_t;

endpackage

>>> hw/rtl/weighted_union_find.sv
// Top level of the weighted quick-union disjoint-set block.
// Depends on wuf_pkg, wuf_front, wuf_fifo and wuf_back.
//
// Keeps a forest over sites_in_use sites (up to MAX_SITES) and takes one
// pair of site indices per transaction on the push/full side; each pair gives
// exactly one result on the empty/pop side, in order. After reset, and after
// every write of sites_in_use, both tables are swept back to their initial
// contents by a sweep over all MAX_SITES entries, during which full
// is held high; configuration writes are still taken and restart the sweep.
// Items are executed one at a time by the back end. A pair with an index at
// or beyond sites_in_use goes straight from idle to its result there. Any
// other pair walks both sites to their roots; a pair whose sites already
// share a root is reported as joined, and a merge then reads the sizes of
// both roots and writes both tables. Depth is the number of parent links from
// a site to its root; weighting bounds the depth to log2(sites_in_use). The
// time an item takes is set by the root walk, which follows one parent link
// per cycle through the single read port of the parent table, and by two
// reads of the size table. Short queues on both sides of the back end let the
// input side keep accepting while a finished result waits to be popped.
module weighted_union_find import wuf_pkg::*; #(
  parameter int MAX_SITES   = 1024,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  // configuration: sites_in_use
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data,
  // input queue side
  input  logic              push,
  output logic              full,
  input  logic [SITE_W-1:0] first_site,
  input  logic [SITE_W-1:0] second_site,
  // result queue side
  output logic              empty,
  input  logic              pop,
  output logic              already_joined,
  output logic              index_error,
  output logic [CNT_W-1:0]  components
);

  wuf_ctl_t ctl;
  wuf_cmd_t cmd_in;
  wuf_cmd_t cmd_out;
  wuf_res_t res_in;
  wuf_res_t res_out;
  logic     clearing;
  logic     cmd_push;
  logic     cmd_full;
  logic     cmd_empty;
  logic     cmd_pop;
  logic     res_push;
  logic     res_full;

  // Accept and classify: range check against sites_in_use
  wuf_front #(
    .MAX_SITES (MAX_SITES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .first_site  (first_site),
    .second_site (second_site),
    .clearing    (clearing),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in),
    .ctl         (ctl)
  );

  // Hold classified items until the back end is free
  wuf_fifo #(
    .W     ($bits(wuf_cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  // Walk, merge and count
  wuf_back #(
    .MAX_SITES (MAX_SITES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .clearing  (clearing),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd_out),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Hold results until popped
  wuf_fifo #(
    .W     ($bits(wuf_res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign already_joined = res_out.already_joined;
  assign index_error    = res_out.index_error;
  assign components     = res_out.components;

endmodule

>>> hw/rtl/wuf_fifo.sv
// Small first-in first-out queue of registers, used between the stages.
// Depends on nothing; DEPTH must be a power of two.
module wuf_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  entry [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/wuf_front.sv
// Front end: holds sites_in_use, range-checks each item and queues it.
// Depends on wuf_pkg.
module wuf_front import wuf_pkg::*; #(
  parameter int MAX_SITES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              push,
  output logic              full,
  input  logic [SITE_W-1:0] first_site,
  input  logic [SITE_W-1:0] second_site,
  input  logic              clearing,
  input  logic              cmd_full,
  output logic              cmd_push,
  output wuf_cmd_t          cmd,
  output wuf_ctl_t          ctl
);

  localparam int SITES_RESET = (MAX_SITES < 1024) ? MAX_SITES : 1024;
  localparam int SITES_CAP   = (MAX_SITES < 2047) ? MAX_SITES : 2047;

  logic [CNT_W-1:0] sites;
  logic [CNT_W-1:0] sites_next;
  logic             cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  // Clamp the written value to 1 .. MAX_SITES, and never beyond 2047
  always_comb begin
    priority if (cfg_data == '0) begin
      sites_next = CNT_W'(1);
    end else if (int'(cfg_data) > SITES_CAP) begin
      sites_next = CNT_W'(SITES_CAP);
    end else begin
      sites_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sites <= CNT_W'(SITES_RESET);
    end else if (cfg_write) begin
      sites <= sites_next;
    end
  end

  assign full     = cmd_full | clearing;
  assign cmd_push = push & ~full;

  always_comb begin
    cmd.first_site  = first_site;
    cmd.second_site = second_site;
    cmd.index_error = ({1'b0, first_site} >= sites) | ({1'b0, second_site} >= sites);
  end

  assign ctl.restart = cfg_write;
  assign ctl.sites   = sites;

endmodule

>>> hw/rtl/wuf_back.sv
// Back end: root walks over the parent table, weighted merge, result build.
// Also runs the clearing sweep of both tables. Depends on wuf_pkg.
module wuf_back import wuf_pkg::*; #(
  parameter int MAX_SITES = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  wuf_ctl_t ctl,
  output logic     clearing,
  input  logic     cmd_empty,
  output logic     cmd_pop,
  input  wuf_cmd_t cmd,
  input  logic     res_full,
  output logic     res_push,
  output wuf_res_t res
);

  localparam int SW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam logic [SW-1:0] LAST = SW'(MAX_SITES - 1);

  typedef enum logic [2:0] {
    CLEAR, IDLE, WALK_A, WALK_B, SIZE_A, SIZE_B, EMIT
  } state_t;

  state_t           state, state_next;
  logic [SW-1:0]    cur, cur_next;
  logic [SW-1:0]    site_b, site_b_next;
  logic [SW-1:0]    root_a, root_a_next;
  logic [SW-1:0]    root_b, root_b_next;
  logic [CNT_W-1:0] size_a, size_a_next;
  logic [CNT_W-1:0] merge_count, merge_count_next;
  logic             joined, joined_next;
  logic             err, err_next;
  logic [SW-1:0]    sweep, sweep_next;

  // Parent table and tree-size table
  logic [SW-1:0]    parent_mem [MAX_SITES];
  logic [CNT_W-1:0] size_mem   [MAX_SITES];
  logic [SW-1:0]    parent_raddr, parent_rdata;
  logic             parent_we;
  logic [SW-1:0]    parent_waddr, parent_wdata;
  logic [SW-1:0]    size_raddr;
  logic [CNT_W-1:0] size_rdata;
  logic             size_we;
  logic [SW-1:0]    size_waddr;
  logic [CNT_W-1:0] size_wdata;
  logic [CNT_W-1:0] size_sum;

  always_ff @(posedge clk) begin
    if (parent_we) begin
      parent_mem[parent_waddr] <= parent_wdata;
    end
    parent_rdata <= parent_mem[parent_raddr];
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_waddr] <= size_wdata;
    end
    size_rdata <= size_mem[size_raddr];
  end

  assign size_sum = size_a + size_rdata;
  assign clearing = (state == CLEAR);

  always_comb begin
    state_next       = state;
    cur_next         = cur;
    site_b_next      = site_b;
    root_a_next      = root_a;
    root_b_next      = root_b;
    size_a_next      = size_a;
    merge_count_next = merge_count;
    joined_next      = joined;
    err_next         = err;
    sweep_next       = sweep;
    parent_raddr     = cur;
    size_raddr       = root_a;
    parent_we        = 1'b0;
    parent_waddr     = root_a;
    parent_wdata     = root_b;
    size_we          = 1'b0;
    size_waddr       = root_a;
    size_wdata       = size_sum;
    cmd_pop          = 1'b0;
    res_push         = 1'b0;

    unique case (state)
      CLEAR: begin
        parent_we    = 1'b1;
        parent_waddr = sweep;
        parent_wdata = sweep;
        size_we      = 1'b1;
        size_waddr   = sweep;
        size_wdata   = CNT_W'(1);
        if (sweep == LAST) begin
          state_next = IDLE;
        end else begin
          sweep_next = sweep + SW'(1);
        end
      end
      IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.index_error) begin
            joined_next = 1'b0;
            err_next    = 1'b1;
            state_next  = EMIT;
          end else begin
            parent_raddr = SW'(cmd.first_site);
            cur_next     = SW'(cmd.first_site);
            site_b_next  = SW'(cmd.second_site);
            state_next   = WALK_A;
          end
        end
      end
      WALK_A: begin
        if (parent_rdata == cur) begin
          root_a_next  = cur;
          parent_raddr = site_b;
          cur_next     = site_b;
          state_next   = WALK_B;
        end else begin
          parent_raddr = parent_rdata;
          cur_next     = parent_rdata;
        end
      end
      WALK_B: begin
        if (parent_rdata == cur) begin
          if (cur == root_a) begin
            joined_next = 1'b1;
            err_next    = 1'b0;
            state_next  = EMIT;
          end else begin
            root_b_next = cur;
            size_raddr  = root_a;
            state_next  = SIZE_A;
          end
        end else begin
          parent_raddr = parent_rdata;
          cur_next     = parent_rdata;
        end
      end
      SIZE_A: begin
        size_a_next = size_rdata;
        size_raddr  = root_b;
        state_next  = SIZE_B;
      end
      SIZE_B: begin
        // hang the smaller tree under the larger; a tie goes under root_a
        parent_we = 1'b1;
        size_we   = 1'b1;
        if (size_a < size_rdata) begin
          parent_waddr = root_a;
          parent_wdata = root_b;
          size_waddr   = root_b;
        end else begin
          parent_waddr = root_b;
          parent_wdata = root_a;
          size_waddr   = root_a;
        end
        merge_count_next = merge_count + CNT_W'(1);
        joined_next      = 1'b0;
        err_next         = 1'b0;
        state_next       = EMIT;
      end
      EMIT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase

    if (ctl.restart) begin
      state_next       = CLEAR;
      sweep_next       = '0;
      merge_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= CLEAR;
      sweep       <= '0;
      merge_count <= '0;
      joined      <= 1'b0;
      err         <= 1'b0;
    end else begin
      state       <= state_next;
      sweep       <= sweep_next;
      merge_count <= merge_count_next;
      joined      <= joined_next;
      err         <= err_next;
    end
    cur    <= cur_next;
    site_b <= site_b_next;
    root_a <= root_a_next;
    root_b <= root_b_next;
    size_a <= size_a_next;
  end

  always_comb begin
    res.already_joined = joined;
    res.index_error    = err;
    res.components     = ctl.sites - merge_count;
  end

  // Every merge joins two components out of the ones in use
  a_merge_bound: assert property (@(posedge clk) disable iff (rst)
    merge_count < ctl.sites)
    else $error("merge count reached sites in use");

  // Tables are written only by the sweep or by a merge
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    (parent_we || size_we) |-> (state == CLEAR || state == SIZE_B))
    else $error("table write outside sweep or merge");

  // A merge never joins a root with itself
  a_distinct_roots: assert property (@(posedge clk) disable iff (rst)
    (state == SIZE_B) |-> (root_a != root_b))
    else $error("merge of equal roots");

  // No item is taken during the sweep
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (state == IDLE && !cmd_empty))
    else $error("command taken outside idle");

  // A delivered result frees the back end for the next item
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (res_push && !ctl.restart) |=> (state == IDLE))
    else $error("back end not idle after result");

endmodule

>>> verif/tb_weighted_union_find.sv
// Self-checking testbench for weighted_union_find: directed pairs, then random
// pairs under several idle mixes, scored against a built-in forest model
// or hand-typed answers. Depends on wuf_pkg and the weighted_union_find RTL only.
module tb_weighted_union_find import wuf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SITES     = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEG_PAIRS   = 94;
  localparam int N_SEGS      = 8;
  localparam int SETTLE      = 60;

  // One row of the directed plan: either a sites_in_use write or a pair,
  // optionally with the result typed in by hand.
  typedef struct {
    bit                is_cfg;
    logic [CNT_W-1:0]  value;
    logic [SITE_W-1:0] a;
    logic [SITE_W-1:0] b;
    bit                fixed;
    wuf_res_t          res;
  } plan_row_t;

  typedef struct {
    bit       fixed;
    wuf_res_t res;
  } hand_res_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data = '0;
  logic              push = 1'b0;
  logic              full;
  logic [SITE_W-1:0] first_site = '0;
  logic [SITE_W-1:0] second_site = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic              already_joined;
  logic              index_error;
  logic [CNT_W-1:0]  components;

  // Forest model: parent links, tree sizes, live site count and merges so far
  logic [SITE_W-1:0] parent_of [N_SITES];
  logic [CNT_W-1:0]  size_of [N_SITES];
  logic [CNT_W-1:0]  sites_live;
  logic [CNT_W-1:0]  merges;

  wuf_res_t  awaited_results[$];
  hand_res_t hand_results[$];
  plan_row_t plan[$];

  int errors = 0;
  int cycles = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_pairs = 0, n_merged = 0, n_joined = 0, n_bad_index = 0, n_cfg = 0;

  wuf_res_t  got, want;
  hand_res_t hand;
  int        seg_cfg [N_SEGS];
  int        span, base;
  logic [SITE_W-1:0] ra, rb;

  weighted_union_find dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .first_site    (first_site),
    .second_site   (second_site),
    .empty         (empty),
    .pop           (pop),
    .already_joined(already_joined),
    .index_error   (index_error),
    .components    (components)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Forest model
  // ---------------------------------------------------------------------------

  // Put every site back in a tree of its own and forget all merges
  function automatic void clear_forest();
    for (int k = 0; k < N_SITES; k++) begin
      parent_of[k] = k[SITE_W-1:0];
      size_of[k]   = CNT_W'(1);
    end
    merges = '0;
  endfunction

  // Follow parent links up to the root; bounded, though a weighted forest
  // never gets anywhere near the bound
  function automatic logic [SITE_W-1:0] find_root(input logic [SITE_W-1:0] s);
    logic [SITE_W-1:0] cur;
    cur = s;
    for (int steps = 0; steps < N_SITES; steps++) begin
      if (parent_of[cur] == cur) break;
      cur = parent_of[cur];
    end
    return cur;
  endfunction

  // Apply one pair to the model and return the result it should produce.
  // The smaller tree goes under the larger; on a tie the second root goes
  // under the first.
  function automatic wuf_res_t join_sites(input logic [SITE_W-1:0] a,
                                          input logic [SITE_W-1:0] b);
    wuf_res_t r;
    r = '0;
    if ({1'b0, a} >= sites_live || {1'b0, b} >= sites_live) begin
      r.index_error = 1'b1;
      n_bad_index++;
    end else begin
      ra = find_root(a);
      rb = find_root(b);
      if (ra == rb) begin
        r.already_joined = 1'b1;
        n_joined++;
      end else if (size_of[ra] < size_of[rb]) begin
        parent_of[ra] = rb;
        size_of[rb]   = size_of[rb] + size_of[ra];
        merges++;
        n_merged++;
      end else begin
        parent_of[rb] = ra;
        size_of[ra]   = size_of[ra] + size_of[rb];
        merges++;
        n_merged++;
      end
    end
    r.components = sites_live - merges;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int seen, input int wanted);
    $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, seen, wanted);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the block's
  // registers move, so the order of processes within the step does not matter.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      sites_live = CNT_W'(N_SITES);
      clear_forest();
    end else begin
      // Score the result side first, so a pair accepted in this same cycle
      // cannot be mistaken for the one being popped
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", int'(components), 0);
        end else begin
          want = awaited_results.pop_front();
          if (already_joined !== want.already_joined)
            report_mismatch("already_joined", int'(already_joined),
                            int'(want.already_joined));
          if (index_error !== want.index_error)
            report_mismatch("index_error", int'(index_error), int'(want.index_error));
          if (components !== want.components)
            report_mismatch("components", int'(components), int'(want.components));
        end
      end
      // A write of sites_in_use clamps to 1..MAX_SITES and rebuilds the forest
      if (cfg_valid && cfg_ready) begin
        if (cfg_data == 0)
          sites_live = CNT_W'(1);
        else if (cfg_data > N_SITES)
          sites_live = CNT_W'(N_SITES);
        else
          sites_live = cfg_data;
        clear_forest();
        n_cfg++;
      end
      if (push && !full) begin
        hand = hand_results.pop_front();
        got  = join_sites(first_site, second_site);
        // Rows with a hand-typed answer are scored against that answer;
        // the model still advances so later rows stay in step
        awaited_results = {awaited_results, (hand.fixed ? hand.res : got)};
        n_pairs++;
      end
    end
  end

  // Receiver: decide pop afresh at every falling edge
  always @(negedge clk) begin
    pop = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, awaited_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one pair; return just after the rising edge that takes it, with push
  // still high, so back-to-back pairs need no extra assignment
  task automatic send_pair(input logic [SITE_W-1:0] a, input logic [SITE_W-1:0] b,
                           input bit fixed, input wuf_res_t res);
    hand_res_t h;
    h.fixed = fixed;
    h.res   = res;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      push = 1'b0;
      @(posedge clk);
    end
    hand_results = {hand_results, h};
    @(negedge clk);
    push        = 1'b1;
    first_site  = a;
    second_site = b;
    do @(posedge clk); while (full);
  endtask

  // Drop push, wait until every outstanding result has been popped
  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Write sites_in_use only once the block has nothing in flight
  task automatic write_sites(input logic [CNT_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic void add_cfg(input int v);
    plan_row_t r;
    r = '{is_cfg: 1'b1, value: CNT_W'(v), a: '0, b: '0, fixed: 1'b0, res: '0};
    plan = {plan, r};
  endfunction

  function automatic void add_pair(input int a, input int b);
    plan_row_t r;
    r = '{is_cfg: 1'b0, value: '0, a: SITE_W'(a), b: SITE_W'(b), fixed: 1'b0, res: '0};
    plan = {plan, r};
  endfunction

  function automatic void add_known(input int a, input int b,
                                    input logic j, input logic e,
                                    input int c);
    plan_row_t r;
    r = '{is_cfg: 1'b0, value: '0, a: SITE_W'(a), b: SITE_W'(b), fixed: 1'b1,
          res: {j, e, CNT_W'(c)}};
    plan = {plan, r};
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed plan. After reset all 1024 sites are live.
    add_known(0, 1023, 1'b0, 1'b0, 1023);    // extremes, equal sizes
    add_known(1023, 0, 1'b1, 1'b0, 1023);    // same pair reversed
    add_known(5, 5, 1'b1, 1'b0, 1023);       // a site joined to itself
    add_cfg(0);                              // clamps up to a single site
    add_known(0, 0, 1'b1, 1'b0, 1);
    add_known(1, 0, 1'b0, 1'b1, 1);          // first index out of range
    add_known(1023, 1023, 1'b0, 1'b1, 1);
    add_cfg(2047);                           // clamps down to 1024, all bits set
    add_known(1023, 512, 1'b0, 1'b0, 1023);
    add_known(512, 1023, 1'b1, 1'b0, 1023);
    add_cfg(8);
    add_known(8, 0, 1'b0, 1'b1, 8);          // index equal to the site count
    add_known(0, 8, 1'b0, 1'b1, 8);          // second index out of range
    add_known(7, 0, 1'b0, 1'b0, 7);
    add_pair(1, 2);
    add_pair(1, 0);                          // tie of two-site trees
    add_pair(3, 4);
    add_pair(5, 3);                          // smaller first tree goes under
    add_pair(3, 6);
    add_pair(6, 1);                          // tie of four-site trees
    add_pair(2, 4);                          // already joined
    add_pair(0, 5);

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        write_sites(plan[i].value);
      else
        send_pair(plan[i].a, plan[i].b, plan[i].fixed, plan[i].res);
    end

    // Random part: pairs of segments share an idle mix, each segment starts
    // from a fresh forest of its own size
    seg_cfg = '{1024, 20, 2047, 1, 0, 3, $urandom_range(2, 1024), 64};
    for (int seg = 0; seg < N_SEGS; seg++) begin
      write_sites(CNT_W'(seg_cfg[seg]));
      unique case (seg / 2)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin sender_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int i = 0; i < SEG_PAIRS; i++) begin
        if ($urandom_range(0, 99) < 8) begin
          // noise: any 10-bit index, mostly out of range on small forests
          send_pair(SITE_W'($urandom_range(0, 1023)), SITE_W'($urandom_range(0, 1023)),
                    1'b0, '0);
        end else begin
          // keep big forests busy in a narrow window so trees grow deep
          if (sites_live > 64 && $urandom_range(0, 1))
            span = 48;
          else
            span = sites_live;
          base = $urandom_range(0, sites_live - span);
          send_pair(SITE_W'(base + $urandom_range(0, span - 1)),
                    SITE_W'(base + $urandom_range(0, span - 1)), 1'b0, '0);
        end
      end
    end

    // Let everything come back, then hold a little longer to catch strays
    drain();
    recv_stall_pct = 0;
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d pairs over %0d sites_in_use writes: %0d merges, %0d already joined,",
             n_pairs, n_cfg, n_merged, n_joined);
    $display("%0d out of range; idle mixes none, sender 76%%, receiver 76%%, both 17%%",
             n_bad_index);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
